// ===== rtl/pstt_pkg.sv =====
package pstt_pkg;

  localparam int MAX_SERVICES = 16;
  localparam int SLOT_W = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
  localparam int CNT_W = $clog2(MAX_SERVICES + 1);
  localparam int RDY_W = (MAX_SERVICES > 16) ? MAX_SERVICES : 16;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_CHECK  = 2'd1,
    FN_REBASE = 2'd2,
    FN_ACK    = 2'd3
  } pstt_func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NULL_TASK = 2'd1,
    ST_ZERO_PER  = 2'd2,
    ST_FULL      = 2'd3
  } pstt_status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [31:0] start_offset;
    logic [31:0] repeat_period;
    logic [7:0]  task_id;
    logic [31:0] time_shift;
    logic [3:0]  ack_slot;
  } pstt_item_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic load_out;
  } pstt_cmd_t;

  typedef struct packed {
    logic scan_go;
    logic scan_last;
  } pstt_sts_t;

endpackage

// ===== rtl/pstt_if.sv =====
interface pstt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;
  logic [31:0] start_offset;
  logic [31:0] repeat_period;
  logic [7:0]  task_id;
  logic [31:0] time_shift;
  logic [3:0]  ack_slot;

  modport source (
    output valid, func, now_ms, start_offset, repeat_period, task_id, time_shift, ack_slot,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, start_offset, repeat_period, task_id, time_shift, ack_slot,
    output ready
  );
endinterface

interface pstt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  added_slot;
  logic [15:0] ready_mask;
  logic [31:0] check_time;

  modport source (
    output valid, status, added_slot, ready_mask, check_time,
    input  ready
  );
  modport sink (
    input  valid, status, added_slot, ready_mask, check_time,
    output ready
  );
endinterface

// ===== rtl/pstt_ram.sv =====
module pstt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pstt_ctrl.sv =====
module pstt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pstt_pkg::pstt_sts_t sts,
  output pstt_pkg::pstt_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.exec     = (state_r == S_EXEC);
    cmd.scan     = (state_r == S_SCAN);
    cmd.load_out = (state_r == S_FIN) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = sts.scan_go ? S_SCAN : S_FIN;
      S_SCAN: if (sts.scan_last) state_nxt = S_FIN;
      S_FIN:  if (cmd.load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register frees up as soon as the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && sts.scan_last |=> (state_r == S_FIN))
    else $error("scan did not finish into result stage");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("waiting result dropped");

endmodule

// ===== rtl/pstt_datapath.sv =====
module pstt_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pstt_pkg::pstt_item_t in_item,
  input  pstt_pkg::pstt_cmd_t  cmd,
  output pstt_pkg::pstt_sts_t  sts,
  output logic [1:0]           out_status,
  output logic [3:0]           out_added_slot,
  output logic [15:0]          out_ready_mask,
  output logic [31:0]          out_check_time
);

  localparam int SLOT_W = pstt_pkg::SLOT_W;
  localparam int CNT_W  = pstt_pkg::CNT_W;
  localparam int NSLOT  = pstt_pkg::MAX_SERVICES;

  pstt_pkg::pstt_item_t   item_r;
  pstt_pkg::pstt_func_t   func;
  pstt_pkg::pstt_status_t add_status;

  logic [CNT_W-1:0]  slot_cnt_r, slot_cnt_nxt;
  logic [NSLOT-1:0]  ready_r, ready_nxt;
  logic [31:0]       next_chk_r, next_chk_nxt;
  logic [31:0]       best_r, best_nxt;
  logic [SLOT_W-1:0] pidx_r;
  logic [1:0]        res_status_r;
  logic [3:0]        res_added_r;

  logic [CNT_W-1:0]  cnt_m1;
  logic [SLOT_W-1:0] last_slot;
  logic [SLOT_W-1:0] slot_idx;
  logic [31:0]       slot_wide;
  logic              full;
  logic              add_ok;
  logic              check_go;
  logic [31:0]       add_due;

  logic [SLOT_W-1:0] raddr;
  logic [SLOT_W-1:0] due_waddr;
  logic              due_we;
  logic [31:0]       due_wdata;
  logic [31:0]       due_rd;
  logic [31:0]       per_rd;
  logic              overdue;
  logic [31:0]       adv_due;
  logic [31:0]       reb_due;
  logic [pstt_pkg::RDY_W-1:0] ready_wide;

  assign func      = pstt_pkg::pstt_func_t'(item_r.func);
  assign full      = (slot_cnt_r == CNT_W'(NSLOT));
  assign cnt_m1    = slot_cnt_r - CNT_W'(1);
  assign last_slot = cnt_m1[SLOT_W-1:0];
  assign slot_idx  = slot_cnt_r[SLOT_W-1:0];
  assign slot_wide = 32'(slot_cnt_r);
  assign add_due   = item_r.start_offset + item_r.now_ms;

  // null task wins over zero period, which wins over full table
  always_comb begin
    priority if (item_r.task_id == 8'd0) begin
      add_status = pstt_pkg::ST_NULL_TASK;
    end else if (item_r.repeat_period == 32'd0) begin
      add_status = pstt_pkg::ST_ZERO_PER;
    end else if (full) begin
      add_status = pstt_pkg::ST_FULL;
    end else begin
      add_status = pstt_pkg::ST_OK;
    end
  end

  assign add_ok   = (func == pstt_pkg::FN_ADD) && (add_status == pstt_pkg::ST_OK);
  assign check_go = (func == pstt_pkg::FN_CHECK) && (item_r.now_ms >= next_chk_r);

  assign sts.scan_go   = (check_go || (func == pstt_pkg::FN_REBASE)) && (slot_cnt_r != '0);
  assign sts.scan_last = (pidx_r == '0);

  // scan walks from the top slot down, one slot per cycle
  assign raddr = cmd.exec ? last_slot : (pidx_r - SLOT_W'(1));

  assign overdue = item_r.now_ms > due_rd;
  assign adv_due = overdue ? (due_rd + per_rd) : due_rd;
  assign reb_due = (due_rd < item_r.time_shift) ? 32'd0 : (due_rd - item_r.time_shift);
  // zero running minimum counts as unset
  assign best_nxt = ((best_r == 32'd0) || (adv_due < best_r)) ? adv_due : best_r;

  assign due_we    = (cmd.exec && add_ok) || cmd.scan;
  assign due_waddr = cmd.scan ? pidx_r : slot_idx;
  assign due_wdata = cmd.scan ? ((func == pstt_pkg::FN_REBASE) ? reb_due : adv_due) : add_due;

  pstt_ram #(.WIDTH(32), .DEPTH(NSLOT)) u_due_ram (
    .clk   (clk),
    .we    (due_we),
    .waddr (due_waddr),
    .wdata (due_wdata),
    .raddr (raddr),
    .rdata (due_rd)
  );

  pstt_ram #(.WIDTH(32), .DEPTH(NSLOT)) u_period_ram (
    .clk   (clk),
    .we    (cmd.exec && add_ok),
    .waddr (slot_idx),
    .wdata (item_r.repeat_period),
    .raddr (raddr),
    .rdata (per_rd)
  );

  always_comb begin
    ready_nxt = ready_r;
    for (int i = 0; i < NSLOT; i++) begin
      if (cmd.exec && add_ok && (slot_cnt_r == CNT_W'(i))) begin
        ready_nxt[i] = 1'b0;
      end
      if (cmd.exec && (func == pstt_pkg::FN_ACK) && (32'(item_r.ack_slot) == 32'(i))) begin
        ready_nxt[i] = 1'b0;
      end
      if (cmd.scan && (func == pstt_pkg::FN_CHECK) && overdue && (pidx_r == SLOT_W'(i))) begin
        ready_nxt[i] = 1'b1;
      end
    end
  end

  always_comb begin
    slot_cnt_nxt = slot_cnt_r;
    next_chk_nxt = next_chk_r;
    if (cmd.exec) begin
      if (add_ok) begin
        slot_cnt_nxt = slot_cnt_r + CNT_W'(1);
        if (add_due < next_chk_r) begin
          next_chk_nxt = add_due;
        end
      end
      if (check_go || (func == pstt_pkg::FN_REBASE)) begin
        next_chk_nxt = 32'd0;
      end
    end
    if (cmd.scan && sts.scan_last && (func == pstt_pkg::FN_CHECK)) begin
      next_chk_nxt = best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
      ready_r    <= '0;
      next_chk_r <= 32'd0;
    end else begin
      slot_cnt_r <= slot_cnt_nxt;
      ready_r    <= ready_nxt;
      next_chk_r <= next_chk_nxt;
    end
  end

  assign ready_wide = pstt_pkg::RDY_W'(ready_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      best_r       <= 32'd0;
      pidx_r       <= last_slot;
      res_status_r <= (func == pstt_pkg::FN_ADD) ? add_status : pstt_pkg::ST_OK;
      res_added_r  <= add_ok ? slot_wide[3:0] : 4'd0;
    end else if (cmd.scan) begin
      best_r <= best_nxt;
      pidx_r <= pidx_r - SLOT_W'(1);
    end
    if (cmd.load_out) begin
      out_status     <= res_status_r;
      out_added_slot <= res_added_r;
      out_ready_mask <= ready_wide[15:0];
      out_check_time <= next_chk_r;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r <= CNT_W'(NSLOT))
    else $error("slot count beyond table size");

  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && add_ok |=> slot_cnt_r == $past(slot_cnt_r) + CNT_W'(1))
    else $error("successful add did not take a slot");

  a_rebase_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan && sts.scan_last && (func == pstt_pkg::FN_REBASE) |=> next_chk_r == 32'd0)
    else $error("rebase left a check time");

endmodule

// ===== rtl/periodic_service_timer_table_unit.sv =====
// Periodic service table with up to pstt_pkg::MAX_SERVICES slots (due time and period kept
// in two small RAMs). One item is handled at a time. Add, acknowledge, a check that finds
// the time short of the check time, and anything on an empty table go from the execute
// state straight to the result stage; a check that runs and a rebase first walk every
// used slot through the RAM read port once, one slot per cycle, before the result stage.
// A new item is accepted while the previous result still waits.
module periodic_service_timer_table_unit (
  input  logic clk,
  input  logic rst_n,
  pstt_in_if.sink    in_if,
  pstt_out_if.source out_if
);

  pstt_pkg::pstt_item_t in_item;
  pstt_pkg::pstt_cmd_t  cmd;
  pstt_pkg::pstt_sts_t  sts;

  always_comb begin
    in_item.func          = in_if.func;
    in_item.now_ms        = in_if.now_ms;
    in_item.start_offset  = in_if.start_offset;
    in_item.repeat_period = in_if.repeat_period;
    in_item.task_id       = in_if.task_id;
    in_item.time_shift    = in_if.time_shift;
    in_item.ack_slot      = in_if.ack_slot;
  end

  pstt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pstt_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (in_item),
    .cmd            (cmd),
    .sts            (sts),
    .out_status     (out_if.status),
    .out_added_slot (out_if.added_slot),
    .out_ready_mask (out_if.ready_mask),
    .out_check_time (out_if.check_time)
  );

endmodule
